### rtl/tbb_pkg.sv
// shared types and constants for the transformed box bounds core
`default_nettype none

package tbb_pkg;

   localparam int DATA_W      = 32;
   localparam int CELL_W      = 16;
   localparam int CSR_W       = 31;
   localparam int AXES        = 3;
   localparam int REQ_TDATA_W = 296;
   localparam int RSP_TDATA_W = 240;
   localparam int NUM_W       = 31;

   localparam logic [CSR_W-1:0]         CELL_SIZE_RESET = 31'd1048576;
   localparam logic signed [CELL_W-1:0] CELL_MAX        = 16'sh7fff;

   typedef enum logic [1:0] {
      OP_LOAD_ROW = 2'd0,
      OP_MESH     = 2'd1,
      OP_END      = 2'd2
   } op_type;

   localparam logic [1:0] ROW_TRANS   = 2'd3;
   localparam logic [1:0] TERM_X      = 2'd0;
   localparam logic [1:0] TERM_Z      = 2'd2;
   localparam logic [1:0] LAST_COORD  = 2'd2;
   localparam logic [2:0] LAST_CORNER = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MESH  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_PUSH  = 5'b10000
   } state_type;

   typedef struct packed {
      logic                     vld;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] add;
      logic [1:0]               term;
      logic [1:0]               coord;
      logic                     last;
   } mac_issue_type;

   typedef struct packed {
      logic                     vld;
      logic signed [DATA_W-1:0] value;
      logic [1:0]               coord;
      logic                     last;
   } mac_wb_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [CELL_W-1:0] grid_pos;
   } div_stat_type;

endpackage

`default_nettype wire

### rtl/tbb_mac.sv
// shared multiply, shift, accumulate and saturate unit
`default_nettype none

module tbb_mac import tbb_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire mac_issue_type issue,
   output mac_wb_type         wb
);

   localparam int ACC_W = 2 * DATA_W + 2 - FRAC_BITS;

   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic                       p_vld_ff;
   logic [1:0]                 p_term_ff;
   logic [1:0]                 p_coord_ff;
   logic                       p_last_ff;
   logic signed [DATA_W-1:0]   p_add_ff;

   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    shf;
   logic signed [ACC_W-1:0]    base;
   logic                       a_vld_ff;
   logic [1:0]                 a_coord_ff;
   logic                       a_last_ff;

   logic [ACC_W-32:0]          acc_hi;
   logic                       fits;
   logic signed [DATA_W-1:0]   sat_in;
   mac_wb_type                 wb_ff;

   assign prod_in = issue.a * issue.b;

   // floor of product over one, then exact sum of four terms
   assign shf    = ACC_W'($signed(prod_ff[2*DATA_W-1:FRAC_BITS]));
   assign base   = (p_term_ff == TERM_X) ? ACC_W'(p_add_ff) : acc_ff;
   assign acc_in = base + shf;

   assign acc_hi = acc_ff[ACC_W-1:DATA_W-1];
   assign fits   = (&acc_hi) || !(|acc_hi);
   always_comb begin
      if (fits) begin
         sat_in = acc_ff[DATA_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_in = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_in = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      p_term_ff  <= issue.term;
      p_coord_ff <= issue.coord;
      p_last_ff  <= issue.last;
      p_add_ff   <= issue.add;
      acc_ff     <= acc_in;
      a_coord_ff <= p_coord_ff;
      a_last_ff  <= p_last_ff;
      wb_ff.value <= sat_in;
      wb_ff.coord <= a_coord_ff;
      wb_ff.last  <= a_last_ff;
      if (reset) begin
         p_vld_ff  <= 1'b0;
         a_vld_ff  <= 1'b0;
         wb_ff.vld <= 1'b0;
      end else begin
         p_vld_ff  <= issue.vld;
         a_vld_ff  <= p_vld_ff && (p_term_ff == TERM_Z);
         wb_ff.vld <= a_vld_ff;
      end
   end

   assign wb = wb_ff;

endmodule

`default_nettype wire

### rtl/tbb_div.sv
// bit-serial floor division of a translation by the cell size
`default_nettype none

module tbb_div import tbb_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [DATA_W-1:0] numer,
   input  wire logic [CSR_W-1:0]         cell_size,
   output div_stat_type                  stat
);

   localparam int              CNT_W = $clog2(NUM_W);
   localparam logic [CSR_W-1:0] ONE  = CSR_W'(64'd1 << FRAC_BITS);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     neg_ff, neg_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [NUM_W:0]           rem_ff, rem_in;
   logic [CSR_W-1:0]         den_ff, den_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic [NUM_W:0]           rem_sh;
   logic [NUM_W+1:0]         diff;
   logic                     ge;
   logic signed [CELL_W-1:0] qs;

   assign rem_sh = {rem_ff[NUM_W-1:0], num_ff[NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign ge     = !diff[NUM_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         // negative: floor(t/d) = ~((~t)/d)
         busy_in = 1'b1;
         neg_in  = numer[DATA_W-1];
         num_in  = numer[DATA_W-1] ? ~numer[NUM_W-1:0] : numer[NUM_W-1:0];
         rem_in  = '0;
         den_in  = (cell_size < ONE) ? ONE : cell_size;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[NUM_W:0] : rem_sh;
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign qs = (|num_ff[NUM_W-1:CELL_W-1]) ? CELL_MAX : $signed(num_ff[CELL_W-1:0]);

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.grid_pos = neg_ff ? ~qs : qs;

endmodule

`default_nettype wire

### rtl/transformed_box_bounds_core.sv
// transformed box bounds core: world box of mesh boxes under a loaded matrix
// matrix row and ignored requests: ready again on the next cycle
// mesh box: 72 products through one shared multiplier, next request taken after the last write-back
// end of model: three 31-step serial divisions, then the response
// synchronous active-high reset clears matrix, running box and cell size to defaults
`default_nettype none

module transformed_box_bounds_core import tbb_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // row_index, entry_a, entry_b, entry_c, low_x, low_y, low_z, high_x, high_y, high_z
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  wire logic [1:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, cell_x, cell_y, cell_z
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // any_mesh
   output logic [0:0]                  rsp_tuser,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_W-1:0]       csr_wdata
);

   state_type                state_ff, state_in;
   logic signed [DATA_W-1:0] mat_ff [AXES][AXES];
   logic signed [DATA_W-1:0] mat_in [AXES][AXES];
   logic signed [DATA_W-1:0] trans_ff [AXES];
   logic signed [DATA_W-1:0] trans_in [AXES];
   logic signed [DATA_W-1:0] lo_ff [AXES];
   logic signed [DATA_W-1:0] lo_in [AXES];
   logic signed [DATA_W-1:0] hi_ff [AXES];
   logic signed [DATA_W-1:0] hi_in [AXES];
   logic signed [DATA_W-1:0] run_min_ff [AXES];
   logic signed [DATA_W-1:0] run_min_in [AXES];
   logic signed [DATA_W-1:0] run_max_ff [AXES];
   logic signed [DATA_W-1:0] run_max_in [AXES];
   logic signed [CELL_W-1:0] cell_ff [AXES];
   logic signed [CELL_W-1:0] cell_in [AXES];
   logic                     seen_ff, seen_in;
   logic [CSR_W-1:0]         cell_size_ff, cell_size_in;
   logic [1:0]               term_ff, term_in;
   logic [1:0]               coord_ff, coord_in;
   logic [2:0]               corner_ff, corner_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic                     rsp_any_ff, rsp_any_in;

   logic                     req_accept;
   op_type                   req_opcode;
   logic [1:0]               req_row_index;
   logic signed [DATA_W-1:0] req_entry [AXES];
   logic signed [DATA_W-1:0] req_low [AXES];
   logic signed [DATA_W-1:0] req_high [AXES];
   logic signed [DATA_W-1:0] trans_sel;
   logic signed [DATA_W-1:0] out_min [AXES];
   logic signed [DATA_W-1:0] out_max [AXES];
   logic                     rsp_load;
   logic                     div_start;
   mac_issue_type            issue;
   mac_wb_type               wb;
   div_stat_type             div_stat;

   assign req_opcode    = op_type'(req_tuser);
   assign req_row_index = req_tdata[1:0];
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         req_entry[i] = req_tdata[2 + DATA_W*i +: DATA_W];
         req_low[i]   = req_tdata[2 + DATA_W*(AXES + i) +: DATA_W];
         req_high[i]  = req_tdata[2 + DATA_W*(2*AXES + i) +: DATA_W];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign trans_sel  = trans_ff[coord_ff];

   // corner bit k selects high over low on axis k
   assign issue.vld   = (state_ff == ST_MESH);
   assign issue.a     = corner_ff[term_ff] ? hi_ff[term_ff] : lo_ff[term_ff];
   assign issue.b     = mat_ff[term_ff][coord_ff];
   assign issue.add   = trans_sel;
   assign issue.term  = term_ff;
   assign issue.coord = coord_ff;
   assign issue.last  = (term_ff == TERM_Z) && (coord_ff == LAST_COORD) &&
                        (corner_ff == LAST_CORNER);

   assign div_start = (state_ff == ST_DIV) && !div_stat.busy && !div_stat.done;
   assign rsp_load  = (state_ff == ST_PUSH) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         out_min[i] = seen_ff ? run_min_ff[i] : trans_ff[i];
         out_max[i] = seen_ff ? run_max_ff[i] : trans_ff[i];
      end
   end

   tbb_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .wb    (wb)
   );

   tbb_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numer     (trans_sel),
      .cell_size (cell_size_ff),
      .stat      (div_stat)
   );

   always_comb begin
      state_in      = state_ff;
      mat_in        = mat_ff;
      trans_in      = trans_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      cell_in       = cell_ff;
      seen_in       = seen_ff;
      term_in       = term_ff;
      coord_in      = coord_ff;
      corner_in     = corner_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_any_in    = rsp_any_ff;
      cell_size_in  = csr_valid ? csr_wdata : cell_size_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               term_in   = '0;
               coord_in  = '0;
               corner_in = '0;
               case (req_opcode)
                  OP_LOAD_ROW: begin
                     for (int i = 0; i < AXES; i++) begin
                        if (req_row_index == ROW_TRANS) begin
                           trans_in[i] = req_entry[i];
                        end else begin
                           mat_in[req_row_index][i] = req_entry[i];
                        end
                     end
                  end
                  OP_MESH: begin
                     lo_in    = req_low;
                     hi_in    = req_high;
                     state_in = ST_MESH;
                  end
                  OP_END: begin
                     state_in = ST_DIV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MESH: begin
            if (term_ff == TERM_Z) begin
               term_in = '0;
               if (coord_ff == LAST_COORD) begin
                  coord_in = '0;
                  if (corner_ff == LAST_CORNER) begin
                     state_in = ST_DRAIN;
                  end else begin
                     corner_in = corner_ff + 1'b1;
                  end
               end else begin
                  coord_in = coord_ff + 1'b1;
               end
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (wb.vld && wb.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               cell_in[coord_ff] = div_stat.grid_pos;
               if (coord_ff == LAST_COORD) begin
                  state_in = ST_PUSH;
               end else begin
                  coord_in = coord_ff + 1'b1;
               end
            end
         end
         ST_PUSH: begin
            if (rsp_load) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {cell_ff[2], cell_ff[1], cell_ff[0],
                                out_max[2], out_max[1], out_max[0],
                                out_min[2], out_min[1], out_min[0]};
               rsp_any_in    = seen_ff;
               for (int i = 0; i < AXES; i++) begin
                  run_min_in[i] = '0;
                  run_max_in[i] = '0;
               end
               seen_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // running box update from the shared unit
      if (wb.vld) begin
         if (!seen_ff) begin
            run_min_in[wb.coord] = wb.value;
            run_max_in[wb.coord] = wb.value;
         end else begin
            if (wb.value < run_min_ff[wb.coord]) begin
               run_min_in[wb.coord] = wb.value;
            end
            if (wb.value > run_max_ff[wb.coord]) begin
               run_max_in[wb.coord] = wb.value;
            end
         end
         if (wb.coord == LAST_COORD) begin
            seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      cell_ff      <= cell_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_any_ff   <= rsp_any_in;
      term_ff      <= term_in;
      coord_ff     <= coord_in;
      corner_ff    <= corner_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         seen_ff       <= 1'b0;
         cell_size_ff  <= CELL_SIZE_RESET;
         for (int i = 0; i < AXES; i++) begin
            trans_ff[i]   <= '0;
            run_min_ff[i] <= '0;
            run_max_ff[i] <= '0;
            for (int j = 0; j < AXES; j++) begin
               mat_ff[i][j] <= '0;
            end
         end
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         seen_ff       <= seen_in;
         cell_size_ff  <= cell_size_in;
         trans_ff      <= trans_in;
         run_min_ff    <= run_min_in;
         run_max_ff    <= run_max_in;
         mat_ff        <= mat_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_any_ff;

`ifndef SYNTH
   a_wb_in_mesh: assert property (@(posedge clock) disable iff (reset)
      wb.vld |-> (state_ff == ST_MESH || state_ff == ST_DRAIN))
      else $error("box update outside mesh processing");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("cell result outside end processing");

   a_clear_on_push: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> !seen_ff && rsp_tvalid_ff)
      else $error("running box not cleared on response");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (run_min_ff[0] <= run_max_ff[0]) &&
                  (run_min_ff[1] <= run_max_ff[1]) &&
                  (run_min_ff[2] <= run_max_ff[2]))
      else $error("running minimum above maximum");
`endif

endmodule

`default_nettype wire
